// ----- hdl/utf8vr_pkg.sv -----
// utf8vr_pkg: shared types, constants and decode functions for the UTF-8
// validating decoder. No dependencies.
package utf8vr_pkg;

  localparam logic [31:0] REPL_BYTES = 32'h00BD_BFEF;
  localparam logic [2:0]  REPL_LEN   = 3'd3;

  // Work item passed from the front end to the back end through the queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       flush;
  } item_t;

  // Sequence length from a lead byte; zero for a byte that cannot lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b[7] == 1'b0)              n = 3'd1;
    else if (b[7:5] == 3'b110)     n = 3'd2;
    else if (b[7:4] == 4'b1110)    n = 3'd3;
    else if (b[7:3] == 5'b11110)   n = 3'd4;
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // Full check of a complete sequence of length n (1..4).
  function automatic logic seq_ok(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [2:0] n);
    logic ok;
    ok = 1'b0;
    case (n)
      3'd1: ok = (b0 < 8'h80);
      3'd2: ok = is_cont(b1) && (b0 >= 8'hC2);
      3'd3: ok = is_cont(b1) && is_cont(b2)
                 && !((b0 == 8'hE0) && (b1 < 8'hA0))
                 && !((b0 == 8'hED) && (b1 >= 8'hA0));
      3'd4: ok = is_cont(b1) && is_cont(b2) && is_cont(b3)
                 && !((b0 == 8'hF0) && (b1 < 8'h90))
                 && !((b0 == 8'hF4) && (b1 >= 8'h90))
                 && (b0 <= 8'hF4);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ----- hdl/utf8vr_if.sv -----
// utf8vr_if: valid/ready channel interfaces for the byte input and the
// character output. No dependencies.
interface utf8vr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_call;
  logic       keep_pending;

  modport source (output valid, data_byte, has_byte, end_of_call, keep_pending,
                  input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_call, keep_pending,
                  output ready);
endinterface

interface utf8vr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] char_bytes;
  logic [2:0]  char_len;
  logic        is_replacement;
  logic        last_of_run;

  modport source (output valid, char_bytes, char_len, is_replacement, last_of_run,
                  input ready);
  modport sink   (input valid, char_bytes, char_len, is_replacement, last_of_run,
                  output ready);
endinterface

// ----- hdl/utf8vr_front.sv -----
// utf8vr_front: accepts input transactions, classifies them and drops the
// ones with no effect. Depends on utf8vr_pkg and utf8vr_in_if.
module utf8vr_front
  import utf8vr_pkg::*;
(
  utf8vr_in_if.sink byte_in,
  input  logic      q_full,
  output logic      q_push,
  output item_t     q_item
);

  logic noop;

  always_comb begin
    q_item.data_byte = byte_in.data_byte;
    q_item.has_byte  = byte_in.has_byte;
    // flush only at end of call outside stream mode
    q_item.flush     = byte_in.end_of_call && !byte_in.keep_pending;
    noop             = !q_item.has_byte && !q_item.flush;
  end

  assign byte_in.ready = !q_full;
  assign q_push        = byte_in.valid && !q_full && !noop;

endmodule

// ----- hdl/utf8vr_queue.sv -----
// utf8vr_queue: two-entry queue of work items between front and back end.
// Depends on utf8vr_pkg.
module utf8vr_queue
  import utf8vr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = fill == 2'd2;
  assign not_empty = fill != 2'd0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hdl/utf8vr_back.sv -----
// utf8vr_back: hold buffer, scan/flush engine and output register.
// Depends on utf8vr_pkg and utf8vr_out_if.
module utf8vr_back
  import utf8vr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  item_t         q_item,
  output logic          q_pop,
  utf8vr_out_if.source  char_out
);

  logic [7:0]  hb [4];
  logic [7:0]  sh [4];
  logic [2:0]  cnt;
  logic        busy;
  logic        flush;
  logic        drain;

  logic        ovalid;
  logic [31:0] obytes;
  logic [2:0]  olen;
  logic        orepl;
  logic        olast;

  logic [2:0]  n;
  logic [2:0]  n2;
  logic        has;
  logic        emit;
  logic        repl;
  logic [2:0]  pop;
  logic [2:0]  cnt_new;
  logic        drain_next;
  logic        more;
  logic        step;
  logic [31:0] word;

  always_comb begin
    n          = lead_len(hb[0]);
    has        = cnt != 3'd0;
    emit       = 1'b0;
    repl       = 1'b1;
    pop        = 3'd0;
    drain_next = drain;
    if (drain) begin
      if (has) begin
        emit = 1'b1;
        pop  = 3'd1;
      end
    end else if (has && n == 3'd0) begin
      emit = 1'b1;
      pop  = 3'd1;
    end else if (has && n <= cnt) begin
      emit = 1'b1;
      if (seq_ok(hb[0], hb[1], hb[2], hb[3], n)) begin
        repl = 1'b0;
        pop  = n;
      end else begin
        pop  = 3'd1;
      end
    end else if (has && flush) begin
      // scan halted on an incomplete sequence: flush the rest one by one
      emit       = 1'b1;
      pop        = 3'd1;
      drain_next = 1'b1;
    end
    cnt_new = cnt - pop;

    sh = hb;
    case (pop)
      3'd1: begin
        sh[0] = hb[1]; sh[1] = hb[2]; sh[2] = hb[3];
      end
      3'd2: begin
        sh[0] = hb[2]; sh[1] = hb[3];
      end
      3'd3: begin
        sh[0] = hb[3];
      end
      default: sh = hb;
    endcase

    n2   = lead_len(sh[0]);
    more = (cnt_new != 3'd0)
           && (drain_next || flush || n2 == 3'd0 || n2 <= cnt_new);

    for (int i = 0; i < 4; i++) begin
      word[8*i +: 8] = (3'(i) < n) ? hb[i] : 8'h00;
    end
  end

  assign step  = busy && (!ovalid || char_out.ready);
  assign q_pop = !busy && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= 3'd0;
      drain  <= 1'b0;
      flush  <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (step && emit) ovalid <= 1'b1;
      else if (char_out.valid && char_out.ready) ovalid <= 1'b0;
      if (step) begin
        cnt   <= cnt_new;
        drain <= drain_next;
        if (!emit || !more) busy <= 1'b0;
      end else if (q_pop) begin
        busy  <= 1'b1;
        flush <= q_item.flush;
        drain <= 1'b0;
        if (q_item.has_byte) cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hb <= sh;
      if (emit) begin
        obytes <= repl ? REPL_BYTES : word;
        olen   <= repl ? REPL_LEN : n;
        orepl  <= repl;
        olast  <= !more;
      end
    end else if (q_pop && q_item.has_byte) begin
      hb[cnt[1:0]] <= q_item.data_byte;
    end
  end

  assign char_out.valid          = ovalid;
  assign char_out.char_bytes     = obytes;
  assign char_out.char_len       = olen;
  assign char_out.is_replacement = orepl;
  assign char_out.last_of_run    = olast;

endmodule

// ----- hdl/utf8_validate_replace_core.sv -----
// utf8_validate_replace_core: UTF-8 validating decoder with U+FFFD replacement.
// Path: an accepted byte is registered in the queue, then in the hold buffer, and its
//   character in the output register. The back-end engine loads a transaction, then emits
//   the characters it yields (up to four) one by one; it pops no new one until done.
// Reset (rst, synchronous): empties the queue, the hold buffer and the output register.
// Depends on utf8vr_pkg, utf8vr_if, utf8vr_front, utf8vr_queue, utf8vr_back.
module utf8_validate_replace_core
  import utf8vr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  utf8vr_in_if.sink    byte_in,
  utf8vr_out_if.source char_out
);

  // Front end: take transactions, drop those with neither a byte nor a flush.
  logic  q_full;
  logic  q_push;
  item_t q_item_in;

  utf8vr_front u_front (
    .byte_in (byte_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_item_in)
  );

  // Decouple the two sides so input keeps flowing while results stall.
  logic  q_pop;
  logic  q_valid;
  item_t q_head;

  utf8vr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Back end: append the byte, scan the hold buffer, emit one character per cycle while the output is taken.
  utf8vr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_head),
    .q_pop    (q_pop),
    .char_out (char_out)
  );

endmodule
